FILE: design/bscp_pkg.sv
// Shared constants for the ball-socket constraint projection block.
`default_nettype none
package bscp_pkg;
    localparam int ADDR_W = 3;
    localparam int TOL_W = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;
    localparam logic REG_ERROR_TOLERANCE = 1'b0;
endpackage
`default_nettype wire

FILE: design/bscp_sqrt_cell.sv
// One digit step of the pipelined integer square root chain.
`default_nettype none
module bscp_sqrt_cell #(
    parameter int SQW = 66,
    parameter int RTW = 33,
    parameter int SW = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire logic [SQW-1:0] i_rad,
    input  wire logic [RTW+1:0] i_rem,
    input  wire logic [RTW-1:0] i_root,
    input  wire logic [SW-1:0]  i_side,
    output logic      [SQW-1:0] o_rad,
    output logic      [RTW+1:0] o_rem,
    output logic      [RTW-1:0] o_root,
    output logic      [SW-1:0]  o_side
);
    localparam int RMW = RTW + 2;

    logic [SQW-1:0] r_rad, n_rad;
    logic [RMW-1:0] r_rem, n_rem;
    logic [RTW-1:0] r_root, n_root;
    logic [SW-1:0]  r_side;
    logic [RMW+1:0] w_t, w_trial, w_diff;
    logic           w_ge;

    always_comb begin
        w_t = {i_rem, i_rad[SQW-1 -: 2]};
        w_trial = {2'b00, i_root, 2'b01};
        w_diff = w_t - w_trial;
        w_ge = (w_t >= w_trial);
        n_rem = w_ge ? w_diff[RMW-1:0] : w_t[RMW-1:0];
        n_root = {i_root[RTW-2:0], w_ge};
        n_rad = {i_rad[SQW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad <= n_rad;
            r_rem <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_rad = r_rad;
    assign o_rem = r_rem;
    assign o_root = r_root;
    assign o_side = r_side;
endmodule
`default_nettype wire

FILE: design/bscp_div_cell.sv
// One quotient bit step of the pipelined restoring divider, for all lanes.
`default_nettype none
module bscp_div_cell #(
    parameter int LANES = 6,
    parameter int DENW = 66,
    parameter int QW = 33,
    parameter int SW = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [DENW-1:0]             i_den,
    input  wire logic [LANES-1:0][DENW-1:0]  i_r,
    input  wire logic [LANES-1:0][QW-1:0]    i_nq,
    input  wire logic [SW-1:0]               i_side,
    output logic      [DENW-1:0]             o_den,
    output logic      [LANES-1:0][DENW-1:0]  o_r,
    output logic      [LANES-1:0][QW-1:0]    o_nq,
    output logic      [SW-1:0]               o_side
);
    logic [DENW-1:0]            r_den;
    logic [LANES-1:0][DENW-1:0] r_r, n_r;
    logic [LANES-1:0][QW-1:0]   r_nq, n_nq;
    logic [SW-1:0]              r_side;
    logic [LANES-1:0][DENW:0]   w_t, w_diff;
    logic [LANES-1:0]           w_ge;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_t[l] = {i_r[l], i_nq[l][QW-1]};
            w_diff[l] = w_t[l] - {1'b0, i_den};
            w_ge[l] = (w_t[l] >= {1'b0, i_den});
            n_r[l] = w_ge[l] ? w_diff[l][DENW-1:0] : w_t[l][DENW-1:0];
            n_nq[l] = {i_nq[l][QW-2:0], w_ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den <= i_den;
            r_r <= n_r;
            r_nq <= n_nq;
            r_side <= i_side;
        end
    end

    assign o_den = r_den;
    assign o_r = r_r;
    assign o_nq = r_nq;
    assign o_side = r_side;
endmodule
`default_nettype wire

FILE: design/ball_socket_constraint_projection.sv
// Top level of the ball-socket distance constraint projection pipeline.
//
// Channel | Direction | Handshake             | Payload
// --------+-----------+-----------------------+---------------------------------------
// joint   | in        | i_valid / o_ready     | positions, anchor, rest length, masses
// result  | out       | o_valid / i_ready     | corrected positions, was_corrected
// config  | in        | psel/penable/pwrite   | error_tolerance at byte address 0
//
// One transaction enters per cycle while the pipeline is not held.
// Most of the pipeline depth is in the square root cell chain and the divider cell chain,
// one result bit per cell.
// Reset clears the valid bits and the output valid flag, and sets error_tolerance to 1.
// The pipeline holds only when the output register is full, not taken, and
// a finished transaction waits behind it; empty slots are squeezed out.
`default_nettype none
module ball_socket_constraint_projection #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bscp_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_first_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_first_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_first_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_second_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_second_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_second_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_anchor_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_anchor_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_anchor_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_rest_length,
    input  wire logic        [COORD_WIDTH-2:0] i_first_mass,
    input  wire logic        [COORD_WIDTH-2:0] i_second_mass,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed      [COORD_WIDTH-1:0] o_new_first_x,
    output logic signed      [COORD_WIDTH-1:0] o_new_first_y,
    output logic signed      [COORD_WIDTH-1:0] o_new_first_z,
    output logic signed      [COORD_WIDTH-1:0] o_new_second_x,
    output logic signed      [COORD_WIDTH-1:0] o_new_second_y,
    output logic signed      [COORD_WIDTH-1:0] o_new_second_z,
    output logic                               o_was_corrected
);
    localparam int W = COORD_WIDTH;
    localparam int MW = W - 1;
    localparam int CW = W + 1;
    localparam int SQW = 2 * W + 2;
    localparam int RTW = W + 1;
    localparam int RMW = RTW + 2;
    localparam int EW = W + 2;
    localparam int XW = 2 * W + 2;
    localparam int PPW = 2 * W;
    localparam int NUMW = 3 * W + 1;
    localparam int DENW = 2 * W + 2;
    localparam int QW = W + 1;
    localparam int LANES = 6;
    localparam int NV = 4 + RTW + 4 + QW + 1;

    typedef struct packed {
        logic [2:0][W-1:0] p1;
        logic [2:0][W-1:0] p2;
        logic [2:0][W-1:0] a;
        logic [W-1:0]      rest;
        logic [MW-1:0]     m1;
        logic [MW-1:0]     m2;
    } t_in;

    typedef struct packed {
        logic [2:0][W-1:0]       p1;
        logic [2:0][W-1:0]       p2;
        logic [W-1:0]            rest;
        logic [MW-1:0]           m1;
        logic [MW-1:0]           m2;
        logic [W-1:0]            msum;
        logic                    pull;
        logic [1:0][2:0][CW-1:0] mag;
        logic [1:0][2:0]         sgn;
    } t_sd;

    typedef struct packed {
        logic [2:0][W-1:0] p1;
        logic [2:0][W-1:0] p2;
        logic [1:0][2:0]   neg;
        logic              skip;
    } t_dv;

    localparam int SDW = $bits(t_sd);
    localparam int DVW = $bits(t_dv);

    // Configuration register.
    logic [bscp_pkg::TOL_W-1:0] r_tol;
    logic                       w_cfg_sel;

    assign w_cfg_sel = (paddr[bscp_pkg::ADDR_W-1] == bscp_pkg::REG_ERROR_TOLERANCE);
    assign pready = 1'b1;
    assign prdata = w_cfg_sel ? {{(32 - bscp_pkg::TOL_W){1'b0}}, r_tol} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= bscp_pkg::TOL_RESET;
        end else if (psel && penable && pwrite && w_cfg_sel) begin
            r_tol <= pwdata[bscp_pkg::TOL_W-1:0];
        end
    end

    // Flow control.
    logic [NV-1:0] r_vld;
    logic          r_ov;
    logic          w_en;
    logic          w_acc;

    assign w_en = !(r_ov && !i_ready && r_vld[NV-1]);
    assign w_acc = i_valid && w_en;
    assign o_ready = w_en;
    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[NV-2:0], w_acc};
            end
            if (w_en && r_vld[NV-1]) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Input register.
    t_in r_in;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in.p1 <= {i_first_z, i_first_y, i_first_x};
            r_in.p2 <= {i_second_z, i_second_y, i_second_x};
            r_in.a <= {i_anchor_z, i_anchor_y, i_anchor_x};
            r_in.rest <= i_rest_length;
            r_in.m1 <= i_first_mass;
            r_in.m2 <= i_second_mass;
        end
    end

    // Differences, magnitudes and mode.
    t_sd n_sd2, r_sd2, r_sd3, r_sd4;
    logic [2:0][CW-1:0] w_d, w_s1, w_s2, w_ad, w_as1, w_as2;

    always_comb begin
        n_sd2.p1 = r_in.p1;
        n_sd2.p2 = r_in.p2;
        n_sd2.rest = r_in.rest;
        n_sd2.m1 = r_in.m1;
        n_sd2.m2 = r_in.m2;
        n_sd2.msum = {1'b0, r_in.m1} + {1'b0, r_in.m2};
        n_sd2.pull = !r_in.rest[W-1] && (r_in.rest != '0);
        for (int i = 0; i < 3; i++) begin
            w_d[i] = {r_in.p2[i][W-1], r_in.p2[i]} - {r_in.p1[i][W-1], r_in.p1[i]};
            w_s1[i] = {r_in.a[i][W-1], r_in.a[i]} - {r_in.p1[i][W-1], r_in.p1[i]};
            w_s2[i] = {r_in.a[i][W-1], r_in.a[i]} - {r_in.p2[i][W-1], r_in.p2[i]};
            w_ad[i] = w_d[i][CW-1] ? (~w_d[i] + 1'b1) : w_d[i];
            w_as1[i] = w_s1[i][CW-1] ? (~w_s1[i] + 1'b1) : w_s1[i];
            w_as2[i] = w_s2[i][CW-1] ? (~w_s2[i] + 1'b1) : w_s2[i];
            n_sd2.mag[0][i] = n_sd2.pull ? w_ad[i] : w_as1[i];
            n_sd2.mag[1][i] = n_sd2.pull ? w_ad[i] : w_as2[i];
            n_sd2.sgn[0][i] = n_sd2.pull ? w_d[i][CW-1] : w_s1[i][CW-1];
            n_sd2.sgn[1][i] = n_sd2.pull ? w_d[i][CW-1] : w_s2[i][CW-1];
        end
    end

    // Squares and their sum.
    logic [2:0][SQW-1:0] r_sq;
    logic [SQW-1:0]      r_rad;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd2 <= n_sd2;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_sd2.mag[0][i] * r_sd2.mag[0][i];
            end
            r_sd3 <= r_sd2;
            r_rad <= r_sq[0] + r_sq[1] + r_sq[2];
            r_sd4 <= r_sd3;
        end
    end

    // Square root cell chain.
    logic [RTW:0][SQW-1:0] w_qrad;
    logic [RTW:0][RMW-1:0] w_qrem;
    logic [RTW:0][RTW-1:0] w_qroot;
    logic [RTW:0][SDW-1:0] w_qside;

    assign w_qrad[0] = r_rad;
    assign w_qrem[0] = '0;
    assign w_qroot[0] = '0;
    assign w_qside[0] = r_sd4;

    for (genvar k = 0; k < RTW; k++) begin : g_sqrt
        bscp_sqrt_cell #(
            .SQW(SQW),
            .RTW(RTW),
            .SW (SDW)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rad (w_qrad[k]),
            .i_rem (w_qrem[k]),
            .i_root(w_qroot[k]),
            .i_side(w_qside[k]),
            .o_rad (w_qrad[k+1]),
            .o_rem (w_qrem[k+1]),
            .o_root(w_qroot[k+1]),
            .o_side(w_qside[k+1])
        );
    end

    // Length error, skip decision and denominator product.
    t_sd              w_se, r_se;
    logic [RTW-1:0]   w_dist;
    logic [EW-1:0]    w_err;
    logic [CW-1:0]    w_abserr, r_abserr;
    logic             r_eneg, n_skip, r_eskip;
    logic [2*W:0]     r_dm;

    assign w_se = t_sd'(w_qside[RTW]);
    assign w_dist = w_qroot[RTW];

    always_comb begin
        w_err = {1'b0, w_dist} - {{2{w_se.rest[W-1]}}, w_se.rest};
        w_abserr = w_err[EW-1] ? CW'(~w_err + 1'b1) : w_err[CW-1:0];
        n_skip = (w_se.msum == '0) ||
                 (w_se.pull && ((w_dist == '0) ||
                  (w_abserr < {{(CW - bscp_pkg::TOL_W){1'b0}}, r_tol})));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_se <= w_se;
            r_abserr <= w_abserr;
            r_eneg <= w_err[EW-1];
            r_eskip <= n_skip;
            r_dm <= w_dist * w_se.msum;
        end
    end

    // Numerator factor and denominator.
    logic [1:0][2:0][XW-1:0] r_x;
    logic [DENW-1:0]         r_fden, r_gden, r_hden;
    t_dv                     n_fdv, r_fdv, r_gdv, r_hdv;
    logic [MW-1:0]           r_fm1, r_fm2;
    logic [CW-1:0]           w_f;

    always_comb begin
        w_f = r_se.pull ? r_abserr : CW'(1);
        n_fdv.p1 = r_se.p1;
        n_fdv.p2 = r_se.p2;
        n_fdv.skip = r_eskip;
        for (int i = 0; i < 3; i++) begin
            n_fdv.neg[0][i] = r_se.sgn[0][i] ^ (r_se.pull & r_eneg);
            n_fdv.neg[1][i] = r_se.sgn[1][i] ^ (r_se.pull & r_eneg) ^ r_se.pull;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int b = 0; b < 2; b++) begin
                for (int i = 0; i < 3; i++) begin
                    r_x[b][i] <= r_se.mag[b][i] * w_f;
                end
            end
            r_fden <= r_se.pull ? {r_dm, 1'b0} : {{(W + 1){1'b0}}, r_se.msum, 1'b0};
            r_fdv <= n_fdv;
            r_fm1 <= r_se.m1;
            r_fm2 <= r_se.m2;
        end
    end

    // Partial products with the masses, then the full numerator.
    logic [1:0][2:0][PPW-1:0] r_lo, r_hi;
    logic [LANES-1:0][DENW-1:0] r_hr;
    logic [LANES-1:0][QW-1:0]   r_hnq;
    logic [1:0][2:0][NUMW-1:0]  w_num;

    always_comb begin
        for (int b = 0; b < 2; b++) begin
            for (int i = 0; i < 3; i++) begin
                w_num[b][i] = {{(W + 1){1'b0}}, r_lo[b][i]} + {r_hi[b][i], {CW{1'b0}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_lo[0][i] <= r_x[0][i][CW-1:0] * r_fm2;
                r_hi[0][i] <= r_x[0][i][XW-1:CW] * r_fm2;
                r_lo[1][i] <= r_x[1][i][CW-1:0] * r_fm1;
                r_hi[1][i] <= r_x[1][i][XW-1:CW] * r_fm1;
            end
            r_gden <= r_fden;
            r_gdv <= r_fdv;
            for (int b = 0; b < 2; b++) begin
                for (int i = 0; i < 3; i++) begin
                    r_hr[b*3+i] <= {2'b00, w_num[b][i][NUMW-1:QW]};
                    r_hnq[b*3+i] <= w_num[b][i][QW-1:0];
                end
            end
            r_hden <= r_gden;
            r_hdv <= r_gdv;
        end
    end

    // Divider cell chain.
    logic [QW:0][DENW-1:0]             w_vden;
    logic [QW:0][LANES-1:0][DENW-1:0]  w_vr;
    logic [QW:0][LANES-1:0][QW-1:0]    w_vnq;
    logic [QW:0][DVW-1:0]              w_vside;

    assign w_vden[0] = r_hden;
    assign w_vr[0] = r_hr;
    assign w_vnq[0] = r_hnq;
    assign w_vside[0] = r_hdv;

    for (genvar k = 0; k < QW; k++) begin : g_div
        bscp_div_cell #(
            .LANES(LANES),
            .DENW (DENW),
            .QW   (QW),
            .SW   (DVW)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_den (w_vden[k]),
            .i_r   (w_vr[k]),
            .i_nq  (w_vnq[k]),
            .i_side(w_vside[k]),
            .o_den (w_vden[k+1]),
            .o_r   (w_vr[k+1]),
            .o_nq  (w_vnq[k+1]),
            .o_side(w_vside[k+1])
        );
    end

    // Rounding and signed correction.
    t_dv                      w_dv, r_rdv;
    logic [LANES-1:0]         w_rnd;
    logic [LANES-1:0][QW:0]   w_qr;
    logic [LANES-1:0][W+2:0]  w_cq, n_corr, r_corr;

    assign w_dv = t_dv'(w_vside[QW]);

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_rnd[l] = ({w_vr[QW][l], 1'b0} >= {1'b0, w_vden[QW]});
            w_qr[l] = {1'b0, w_vnq[QW][l]} + {{QW{1'b0}}, w_rnd[l]};
            w_cq[l] = {1'b0, w_qr[l]};
            n_corr[l] = w_dv.neg[l/3][l%3] ? ((W + 3)'(0) - w_cq[l]) : w_cq[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_corr <= n_corr;
            r_rdv <= w_dv;
        end
    end

    // Apply, saturate and compare.
    logic [1:0][2:0][W-1:0] w_p, w_new, r_onew;
    logic [LANES-1:0][W+2:0] w_sum;
    logic [LANES-1:0]        w_chg;
    logic                    r_owc;

    assign w_p[0] = r_rdv.p1;
    assign w_p[1] = r_rdv.p2;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_sum[l] = {{3{w_p[l/3][l%3][W-1]}}, w_p[l/3][l%3]} + r_corr[l];
            if (r_rdv.skip) begin
                w_new[l/3][l%3] = w_p[l/3][l%3];
            end else if ((w_sum[l][W+2:W-1] == '0) || (w_sum[l][W+2:W-1] == '1)) begin
                w_new[l/3][l%3] = w_sum[l][W-1:0];
            end else if (w_sum[l][W+2]) begin
                w_new[l/3][l%3] = {1'b1, {(W - 1){1'b0}}};
            end else begin
                w_new[l/3][l%3] = {1'b0, {(W - 1){1'b1}}};
            end
            w_chg[l] = (w_new[l/3][l%3] != w_p[l/3][l%3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_vld[NV-1]) begin
            r_onew <= w_new;
            r_owc <= |w_chg;
        end
    end

    assign o_new_first_x = r_onew[0][0];
    assign o_new_first_y = r_onew[0][1];
    assign o_new_first_z = r_onew[0][2];
    assign o_new_second_x = r_onew[1][0];
    assign o_new_second_y = r_onew[1][1];
    assign o_new_second_z = r_onew[1][2];
    assign o_was_corrected = r_owc;
endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for the ball-socket constraint projection block.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    localparam int CW = 32;
    localparam int LATENCY = 2 * CW + 12;
    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_JOINTS = 1000;

    typedef struct {
        logic signed [CW-1:0] p1 [3];
        logic signed [CW-1:0] p2 [3];
        logic signed [CW-1:0] anc [3];
        logic signed [CW-1:0] rest;
        logic [CW-2:0] m1;
        logic [CW-2:0] m2;
    } t_joint;

    typedef struct {
        logic signed [CW-1:0] n1 [3];
        logic signed [CW-1:0] n2 [3];
        logic corrected;
    } t_pose;

    int error_count = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    endtask

    // Rounded quotient of s * f * w / den, ties away from zero.
    function automatic longint share(input longint s, input longint f, input longint unsigned w,
                                     input logic [127:0] den);
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] r;
        longint unsigned ms;
        longint unsigned mf;
        ms = s < 0 ? -s : s;
        mf = f < 0 ? -f : f;
        num = 128'(ms) * 128'(mf) * 128'(w);
        q = num / den;
        r = num % den;
        if ((r << 1) >= den) q++;
        return ((s < 0) != (f < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned floor_sqrt(input logic [127:0] n);
        longint unsigned res;
        longint unsigned cand;
        res = 0;
        for (int b = 63; b >= 0; b--) begin
            cand = res | (64'd1 << b);
            if (n >= 128'(cand) * 128'(cand)) res = cand;
        end
        return res;
    endfunction

    function automatic t_pose project_joint(input t_joint j,
                                            input logic [bscp_pkg::TOL_W-1:0] tol);
        t_pose p;
        longint d [3];
        longint unsigned msum;
        longint unsigned span;
        longint err;
        logic [127:0] sq;
        logic [127:0] den;
        longint n1;
        longint n2;
        msum = longint'(j.m1) + longint'(j.m2);
        p.corrected = 1'b0;
        for (int i = 0; i < 3; i++) begin
            p.n1[i] = j.p1[i];
            p.n2[i] = j.p2[i];
        end
        if (msum != 0) begin
            if (j.rest > 0) begin
                sq = '0;
                for (int i = 0; i < 3; i++) begin
                    d[i] = longint'(j.p2[i]) - longint'(j.p1[i]);
                    sq += 128'(d[i] < 0 ? -d[i] : d[i]) * 128'(d[i] < 0 ? -d[i] : d[i]);
                end
                span = floor_sqrt(sq);
                err = longint'(span) - longint'(j.rest);
                if (span != 0 && (err < 0 ? -err : err) >= longint'(tol)) begin
                    den = 128'(span) * 128'(msum) * 2;
                    for (int i = 0; i < 3; i++) begin
                        p.n1[i] = CW'(clamp_coord(j.p1[i] + share(d[i], err, j.m2, den)));
                        p.n2[i] = CW'(clamp_coord(j.p2[i] - share(d[i], err, j.m1, den)));
                    end
                end
            end else begin
                den = 128'(msum) * 2;
                for (int i = 0; i < 3; i++) begin
                    n1 = longint'(j.anc[i]) - longint'(j.p1[i]);
                    n2 = longint'(j.anc[i]) - longint'(j.p2[i]);
                    p.n1[i] = CW'(clamp_coord(j.p1[i] + share(n1, 1, j.m2, den)));
                    p.n2[i] = CW'(clamp_coord(j.p2[i] + share(n2, 1, j.m1, den)));
                end
            end
        end
        for (int i = 0; i < 3; i++)
            if (p.n1[i] != j.p1[i] || p.n2[i] != j.p2[i]) p.corrected = 1'b1;
        return p;
    endfunction

    class t_pose_scoreboard;
        t_pose pending [$];
        logic [bscp_pkg::TOL_W-1:0] tolerance = bscp_pkg::TOL_RESET;
        int checked = 0;

        function void note_joint(t_joint j);
            pending.push_back(project_joint(j, tolerance));
        endfunction

        task check_pose(t_pose got);
            t_pose want;
            checked++;
            if (pending.size() == 0) begin
                report_mismatch("unexpected transaction", 0, 0);
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < 3; i++) begin
                if (got.n1[i] !== want.n1[i])
                    report_mismatch($sformatf("new_first[%0d]", i), got.n1[i], want.n1[i]);
                if (got.n2[i] !== want.n2[i])
                    report_mismatch($sformatf("new_second[%0d]", i), got.n2[i], want.n2[i]);
            end
            if (got.corrected !== want.corrected)
                report_mismatch("was_corrected", got.corrected, want.corrected);
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [bscp_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [CW-1:0] i_first_x = '0, i_first_y = '0, i_first_z = '0;
    logic signed [CW-1:0] i_second_x = '0, i_second_y = '0, i_second_z = '0;
    logic signed [CW-1:0] i_anchor_x = '0, i_anchor_y = '0, i_anchor_z = '0;
    logic signed [CW-1:0] i_rest_length = '0;
    logic [CW-2:0] i_first_mass = '0, i_second_mass = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [CW-1:0] o_new_first_x, o_new_first_y, o_new_first_z;
    logic signed [CW-1:0] o_new_second_x, o_new_second_y, o_new_second_z;
    logic o_was_corrected;

    always #5 i_clk = ~i_clk;

    ball_socket_constraint_projection #(.COORD_WIDTH(CW)) dut (.*);

    t_pose_scoreboard board = new();
    bit quiet_mode = 1'b0;
    int idle_cycles = 0;
    int corrected_seen = 0;

    // Result side: random backpressure and checking.
    always @(posedge i_clk) begin
        t_pose got;
        if (i_rst_n && o_valid && i_ready) begin
            got.n1[0] = o_new_first_x;
            got.n1[1] = o_new_first_y;
            got.n1[2] = o_new_first_z;
            got.n2[0] = o_new_second_x;
            got.n2[1] = o_new_second_y;
            got.n2[2] = o_new_second_z;
            got.corrected = o_was_corrected;
            if (o_was_corrected) corrected_seen++;
            board.check_pose(got);
        end
        i_ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 32);
    end

    // The watchdog counts cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog expired with %0d transactions pending", board.pending.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic write_tolerance(input logic [bscp_pkg::TOL_W-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= bscp_pkg::ADDR_W'(4 * bscp_pkg::REG_ERROR_TOLERANCE);
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.tolerance = value;
    endtask

    task automatic drain_results();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_joint(input t_joint j);
        if (!quiet_mode)
            while ($urandom_range(99) < 32) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        i_valid <= 1'b1;
        i_first_x <= j.p1[0];
        i_first_y <= j.p1[1];
        i_first_z <= j.p1[2];
        i_second_x <= j.p2[0];
        i_second_y <= j.p2[1];
        i_second_z <= j.p2[2];
        i_anchor_x <= j.anc[0];
        i_anchor_y <= j.anc[1];
        i_anchor_z <= j.anc[2];
        i_rest_length <= j.rest;
        i_first_mass <= j.m1;
        i_second_mass <= j.m2;
        do @(posedge i_clk); while (!o_ready);
        board.note_joint(j);
    endtask

    task automatic finish_sending();
        i_valid <= 1'b0;
    endtask

    function automatic logic signed [CW-1:0] pick_coord(input int mode);
        case (mode)
            0: return $signed($urandom);
            1: return $signed($urandom_range(20 << 16)) - (10 << 16);
            2: return $signed($urandom_range(600)) - 300;
            default: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
        endcase
    endfunction

    function automatic t_joint random_joint();
        t_joint j;
        int mode;
        mode = $urandom_range(9) < 6 ? 1 : $urandom_range(3);
        for (int i = 0; i < 3; i++) begin
            j.p1[i] = pick_coord(mode);
            j.p2[i] = $urandom_range(4) == 0 ? j.p1[i] : pick_coord(mode);
            j.anc[i] = pick_coord(mode);
        end
        case ($urandom_range(5))
            0: j.rest = $signed($urandom);
            1: j.rest = -$signed(31'($urandom));
            2: j.rest = '0;
            default: j.rest = $urandom_range(12 << 16);
        endcase
        case ($urandom_range(3))
            0: j.m1 = 31'($urandom);
            1: j.m1 = '0;
            default: j.m1 = 31'($urandom_range(1 << 18));
        endcase
        case ($urandom_range(3))
            0: j.m2 = 31'($urandom);
            1: j.m2 = $urandom_range(3) == 0 ? '0 : 31'h7fffffff;
            default: j.m2 = 31'($urandom_range(1 << 18));
        endcase
        return j;
    endfunction

    function automatic t_joint line_joint(input logic signed [CW-1:0] a, input logic signed [CW-1:0] b,
                                          input logic signed [CW-1:0] rest,
                                          input logic [CW-2:0] m1, input logic [CW-2:0] m2);
        t_joint j;
        for (int i = 0; i < 3; i++) begin
            j.p1[i] = i == 0 ? a : '0;
            j.p2[i] = i == 0 ? b : '0;
            j.anc[i] = 32'sh00030000;
        end
        j.rest = rest;
        j.m1 = m1;
        j.m2 = m2;
        return j;
    endfunction

    initial begin
        t_joint j;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed joints at the default tolerance.
        send_joint(line_joint(0, 32'sh00020000, 32'sh00010000, 31'h10000, 31'h10000));
        send_joint(line_joint(0, 32'sh00020000, 32'sh00020000, 31'h10000, 31'h10000));
        send_joint(line_joint(0, 32'sh00020000, 32'sh00020001, 31'h10000, 31'h10000));
        send_joint(line_joint(5, 5, 32'sh00010000, 31'h10000, 31'h10000));
        send_joint(line_joint(0, 32'sh00020000, 32'sh00010000, 31'd0, 31'd0));
        send_joint(line_joint(0, 32'sh00020000, 32'sh00010000, 31'd0, 31'h10000));
        send_joint(line_joint(0, 32'sh00020000, 32'sh00010000, 31'h7fffffff, 31'd0));
        send_joint(line_joint(0, 32'sh00020000, 0, 31'h10000, 31'h30000));
        send_joint(line_joint(0, 32'sh00020000, 32'sh80000000, 31'h7fffffff, 31'h7fffffff));
        send_joint(line_joint(32'sh80000000, 32'sh7fffffff, 1, 31'd1, 31'd1));
        send_joint(line_joint(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 31'h7fffffff, 31'd1));
        send_joint(line_joint(0, 1, 32'sh7fffffff, 31'd1, 31'h7fffffff));
        send_joint(line_joint(0, 3, 1, 31'd1, 31'h7fffffff));
        for (int i = 0; i < 3; i++) begin
            j = line_joint(32'sh80000000, 32'sh7fffffff, -1, 31'd1, 31'd1);
            j.anc[i] = 32'sh7fffffff;
            send_joint(j);
        end
        j = line_joint(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 31'h7fffffff, 31'h7fffffff);
        j.anc[0] = 32'sh80000000;
        send_joint(j);
        finish_sending();
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_tolerance(16'hffff);
                1: write_tolerance(16'h0000);
                2: write_tolerance(16'($urandom_range(16'h1000)));
                default: write_tolerance(bscp_pkg::TOL_RESET);
            endcase
            quiet_mode = (phase == 2);
            for (int n = 0; n < RANDOM_JOINTS / 4; n++) begin
                if (phase == 1 && n == 100) begin
                    finish_sending();
                    while (board.pending.size() != 0) @(posedge i_clk);
                end
                send_joint(random_joint());
            end
            finish_sending();
            drain_results();
        end
        quiet_mode = 1'b0;

        $display("checked %0d joint results, %0d of them corrected,", board.checked,
                 corrected_seen);
        $display("over four tolerance settings with random stalls on both channels.");
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: ball_socket_constraint_projection.f
design/bscp_pkg.sv
design/bscp_sqrt_cell.sv
design/bscp_div_cell.sv
design/ball_socket_constraint_projection.sv
bench/testbench.sv
